// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the top design file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the priority queue controller and datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Operation carried by a request beat.
    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Controller states: no result pending, or a result held for the sink.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_HOLD = 1'b1
    } state_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic    exec;
        op_t     op;
        status_t code;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
    } dp_stat_t;

endpackage

// ===== hdl/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_if
// Valid/ready channels for the priority queue: requests in, results out.
// ----------------------------------------------------------------------------
interface spq_req_if #(
    parameter int ID_BITS       = 16,
    parameter int PRIORITY_BITS = 8
);
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic [ID_BITS-1:0]       entry_id;
    logic [PRIORITY_BITS-1:0] priority_req;

    modport source (output valid, output operation, output entry_id,
                    output priority_req, input ready);
    modport sink   (input valid, input operation, input entry_id,
                    input priority_req, output ready);
endinterface

interface spq_rsp_if #(
    parameter int ID_BITS       = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int CNT_BITS      = 5
);
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [ID_BITS-1:0]       served_id;
    logic [PRIORITY_BITS-1:0] served_priority;
    logic [CNT_BITS-1:0]      occupancy;

    modport source (output valid, output status, output served_id,
                    output served_priority, output occupancy, input ready);
    modport sink   (input valid, input status, input served_id,
                    input served_priority, input occupancy, output ready);
endinterface

// ===== hdl/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue of (id, priority) entries, highest priority first,
// equal priorities served in arrival order.
// A request beat on req carries an operation (enqueue or dequeue), an id and
// a priority. Each request produces exactly one result beat on rsp with a
// status, the served id and priority (zero unless a dequeue succeeded) and
// the occupancy after the operation.
// The result is valid in the cycle after acceptance.
// Throughput is one request per cycle while the sink keeps up; every slot
// compares against the new priority in parallel and all slots shift together.
// While a result waits, a new request is accepted only in a cycle in which
// the sink takes the pending result, so a stalled sink stalls req.
// Reset empties the queue at once; slot contents are left as they are.
// A full queue refuses an enqueue; an empty queue refuses a dequeue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stable_priority_queue #(
    parameter int DEPTH         = 16,
    parameter int ID_BITS       = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    spq_pkg::dp_cmd_t  cmd;
    spq_pkg::dp_stat_t stat;

    // Handshake and decision logic.
    spq_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_operation (req.operation),
        .req_ready     (req.ready),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // Slot array and result registers.
    spq_datapath #(
        .DEPTH         (DEPTH),
        .ID_BITS       (ID_BITS),
        .PRIORITY_BITS (PRIORITY_BITS),
        .CNT_W         (CNT_W)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .entry_id        (req.entry_id),
        .priority_req    (req.priority_req),
        .stat            (stat),
        .status          (rsp.status),
        .served_id       (rsp.served_id),
        .served_priority (rsp.served_priority),
        .occupancy       (rsp.occupancy)
    );

    // Every accepted beat yields a result beat in the next cycle.
    `ASSERT_NEXT(a_accept_gives_result, req.valid && req.ready, rsp.valid, "accepted beat gave no result")

    // Occupancy never exceeds the number of slots.
    `ASSERT_SAME(a_occ_bound, rsp.valid, rsp.occupancy <= CNT_W'(DEPTH), "occupancy above depth")

    // A refused enqueue only happens on a full queue.
    `ASSERT_SAME(a_full_refusal, rsp.valid && rsp.status == spq_pkg::ST_FULL, rsp.occupancy == CNT_W'(DEPTH), "full refusal with free slots")

    // An empty dequeue returns zero fields and an empty queue.
    `ASSERT_SAME(a_empty_result, rsp.valid && rsp.status == spq_pkg::ST_EMPTY, rsp.occupancy == '0 && rsp.served_id == '0 && rsp.served_priority == '0, "bad empty result")

endmodule

// ===== hdl/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: accepts request beats, decides the result code and
// holds the result beat until the sink takes it.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_operation,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  spq_pkg::dp_stat_t stat,
    output spq_pkg::dp_cmd_t  cmd
);

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;
    logic            accept;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state, handshake and command decode.
    always_comb
    begin
        req_ready  = (state_reg == spq_pkg::S_IDLE) || rsp_ready;
        rsp_valid  = (state_reg == spq_pkg::S_HOLD);
        accept     = req_valid && req_ready;
        state_next = state_reg;
        cmd.exec   = accept;
        cmd.op     = spq_pkg::op_t'(req_operation);
        cmd.code   = spq_pkg::ST_DONE;

        // A dequeue on an empty queue or an enqueue on a full one is refused.
        if (cmd.op == spq_pkg::OP_DEQ && stat.empty)
        begin
            cmd.code = spq_pkg::ST_EMPTY;
        end
        else if (cmd.op == spq_pkg::OP_ENQ && stat.full)
        begin
            cmd.code = spq_pkg::ST_FULL;
        end

        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = spq_pkg::S_HOLD;
                end
            end
            spq_pkg::S_HOLD:
            begin
                if (!accept && rsp_ready)
                begin
                    state_next = spq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted slot array with a comparator per slot, entry counter and result
// registers. Slot 0 holds the head; all slots shift together.
// ----------------------------------------------------------------------------
module spq_datapath #(
    parameter int DEPTH         = 16,
    parameter int ID_BITS       = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int CNT_W         = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  spq_pkg::dp_cmd_t         cmd,
    input  logic [ID_BITS-1:0]       entry_id,
    input  logic [PRIORITY_BITS-1:0] priority_req,
    output spq_pkg::dp_stat_t        stat,
    output logic [1:0]               status,
    output logic [ID_BITS-1:0]       served_id,
    output logic [PRIORITY_BITS-1:0] served_priority,
    output logic [CNT_W-1:0]         occupancy
);

    logic [PRIORITY_BITS-1:0] slot_pri_reg [DEPTH];
    logic [ID_BITS-1:0]       slot_id_reg  [DEPTH];
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    spq_pkg::status_t         status_reg;
    logic [ID_BITS-1:0]       served_id_reg;
    logic [PRIORITY_BITS-1:0] served_pri_reg;
    logic [DEPTH-1:0]         keep;
    logic                     do_enq;
    logic                     do_deq;

    assign do_enq = cmd.exec && (cmd.code == spq_pkg::ST_DONE) && (cmd.op == spq_pkg::OP_ENQ);
    assign do_deq = cmd.exec && (cmd.code == spq_pkg::ST_DONE) && (cmd.op == spq_pkg::OP_DEQ);

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    // A slot stays put on enqueue when it is occupied and ranks at or above
    // the new entry; since the array is sorted this marks a prefix.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            keep[i] = (CNT_W'(i) < count_reg) && (slot_pri_reg[i] >= priority_req);
        end
    end

    // Slot array: shift toward the head on dequeue, open a gap on enqueue.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_slot
        always_ff @(posedge clk)
        begin
            if (do_deq)
            begin
                if (g < DEPTH - 1)
                begin
                    slot_pri_reg[g] <= slot_pri_reg[(g + 1) % DEPTH];
                    slot_id_reg[g]  <= slot_id_reg[(g + 1) % DEPTH];
                end
            end
            else if (do_enq && !keep[g])
            begin
                if (g == 0 || keep[(g + DEPTH - 1) % DEPTH])
                begin
                    slot_pri_reg[g] <= priority_req;
                    slot_id_reg[g]  <= entry_id;
                end
                else
                begin
                    slot_pri_reg[g] <= slot_pri_reg[(g + DEPTH - 1) % DEPTH];
                    slot_id_reg[g]  <= slot_id_reg[(g + DEPTH - 1) % DEPTH];
                end
            end
        end
    end

    // Entry counter.
    always_comb
    begin
        count_next = count_reg;
        if (do_enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Result registers, loaded with every accepted beat.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= cmd.code;
            if (do_deq)
            begin
                served_id_reg  <= slot_id_reg[0];
                served_pri_reg <= slot_pri_reg[0];
            end
            else
            begin
                served_id_reg  <= '0;
                served_pri_reg <= '0;
            end
        end
    end

    assign status          = status_reg;
    assign served_id       = served_id_reg;
    assign served_priority = served_pri_reg;
    assign occupancy       = count_reg;

endmodule

// ===== test/queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_checker
// Watches the request and result channels of the priority queue, keeps its
// own sorted copy of the queue, and checks every result beat field by field
// against the result that copy predicts for the matching request beat.
// ----------------------------------------------------------------------------
module queue_checker #(
    parameter int DEPTH  = 16,
    parameter int ID_W   = 16,
    parameter int PRI_W  = 8,
    parameter int CNT_W  = 5
) (
    input  logic clk,
    input  logic rst_n,
    spq_req_if   req,
    spq_rsp_if   rsp,
    output int   mismatches,
    output int   results_pending,
    output int   requests_seen,
    output int   dequeues_served,
    output int   empty_refusals,
    output int   full_refusals
);

    // One predicted result beat.
    typedef struct packed {
        spq_pkg::status_t   status;
        logic [ID_W-1:0]    served_id;
        logic [PRI_W-1:0]   served_pri;
        logic [CNT_W-1:0]   occupancy;
    } queue_result_t;

    // Shadow queue, slot 0 is the head, sorted from highest priority down.
    logic [PRI_W-1:0] held_pri [DEPTH];
    logic [ID_W-1:0]  held_id  [DEPTH];
    int               held_count;

    // Predicted results waiting for their beat on the result channel.
    queue_result_t expected_results [$];

    // Applies one request to the shadow queue and returns the result it causes.
    function automatic queue_result_t apply_queue_op(input spq_pkg::op_t op,
                                                     input logic [ID_W-1:0] id,
                                                     input logic [PRI_W-1:0] pri);
        queue_result_t res;
        int pos;
        res.status     = spq_pkg::ST_DONE;
        res.served_id  = '0;
        res.served_pri = '0;
        if (op == spq_pkg::OP_ENQ)
        begin
            if (held_count >= DEPTH)
            begin
                res.status = spq_pkg::ST_FULL;
            end
            else
            begin
                // A new entry goes behind every entry of equal or higher priority.
                pos = 0;
                while (pos < held_count && held_pri[pos] >= pri)
                    pos++;
                for (int i = held_count; i > pos; i--)
                begin
                    held_pri[i] = held_pri[i-1];
                    held_id[i]  = held_id[i-1];
                end
                held_pri[pos] = pri;
                held_id[pos]  = id;
                held_count++;
            end
        end
        else
        begin
            if (held_count == 0)
            begin
                res.status = spq_pkg::ST_EMPTY;
            end
            else
            begin
                res.served_id  = held_id[0];
                res.served_pri = held_pri[0];
                for (int i = 1; i < held_count; i++)
                begin
                    held_pri[i-1] = held_pri[i];
                    held_id[i-1]  = held_id[i];
                end
                held_count--;
            end
        end
        res.occupancy = CNT_W'(held_count);
        return res;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Result beats are checked before request beats of the same edge are
    // predicted, since a result always belongs to an earlier request.
    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t want;
        if (!rst_n)
        begin
            expected_results.delete();
            held_count      = 0;
            mismatches      = 0;
            requests_seen   = 0;
            dequeues_served = 0;
            empty_refusals  = 0;
            full_refusals   = 0;
            results_pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result beat with no request waiting, status %0d",
                                              rsp.status));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status got %0d, expected %0d",
                                                  rsp.status, want.status));
                    if (rsp.served_id !== want.served_id)
                        report_mismatch($sformatf("served_id got 0x%0h, expected 0x%0h",
                                                  rsp.served_id, want.served_id));
                    if (rsp.served_priority !== want.served_pri)
                        report_mismatch($sformatf("served_priority got 0x%0h, expected 0x%0h",
                                                  rsp.served_priority, want.served_pri));
                    if (rsp.occupancy !== want.occupancy)
                        report_mismatch($sformatf("occupancy got %0d, expected %0d",
                                                  rsp.occupancy, want.occupancy));
                end
            end
            if (req.valid && req.ready)
            begin
                want = apply_queue_op(spq_pkg::op_t'(req.operation), req.entry_id,
                                      req.priority_req);
                expected_results.push_back(want);
                requests_seen++;
                if (want.status == spq_pkg::ST_FULL)
                    full_refusals++;
                else if (want.status == spq_pkg::ST_EMPTY)
                    empty_refusals++;
                else if (spq_pkg::op_t'(req.operation) == spq_pkg::OP_DEQ)
                    dequeues_served++;
            end
            results_pending <= expected_results.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives enqueue and dequeue beats into the priority queue: a directed fill
// with field extremes, ties, a refused enqueue and a dequeue on empty, then
// random bursts that swing the queue between empty and full. Both channels
// stall at random in two of three phases; the checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;

    localparam int QUEUE_DEPTH    = 16;
    localparam int ID_W           = 16;
    localparam int PRI_W          = 8;
    localparam int CNT_W          = 5;
    localparam int ITEMS_PER_PASS = 250;
    // Longest quiet stretch the watchdog allows before it ends the run.
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;

    int mismatches;
    int results_pending;
    int requests_seen;
    int dequeues_served;
    int empty_refusals;
    int full_refusals;

    spq_req_if #(.ID_BITS(ID_W), .PRIORITY_BITS(PRI_W)) req_ch ();
    spq_rsp_if #(.ID_BITS(ID_W), .PRIORITY_BITS(PRI_W), .CNT_BITS(CNT_W)) rsp_ch ();

    stable_priority_queue #(
        .DEPTH         (QUEUE_DEPTH),
        .ID_BITS       (ID_W),
        .PRIORITY_BITS (PRI_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    queue_checker #(
        .DEPTH (QUEUE_DEPTH),
        .ID_W  (ID_W),
        .PRI_W (PRI_W),
        .CNT_W (CNT_W)
    ) checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .mismatches      (mismatches),
        .results_pending (results_pending),
        .requests_seen   (requests_seen),
        .dequeues_served (dequeues_served),
        .empty_refusals  (empty_refusals),
        .full_refusals   (full_refusals)
    );

    // 20 ns clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Result sink: ready drops at random according to the current phase.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no beat for %0d cycles, %0d results still due",
                 WATCHDOG_LIMIT, results_pending);
        $display("testbench NOT OK");
        $finish;
    end

    // Sends one request beat, after a random idle gap, and waits until taken.
    task automatic send_request(input spq_pkg::op_t op, input logic [ID_W-1:0] id,
                                input logic [PRI_W-1:0] pri);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.entry_id     <= id;
        req_ch.priority_req <= pri;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Holds the request channel quiet until every result beat has come back.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
    endtask

    // Directed part: dequeue on empty, a fill with extremes and ties, a
    // refused enqueue on a full queue, then a few dequeues.
    task automatic run_directed();
        logic [ID_W+PRI_W-1:0] fill [QUEUE_DEPTH];
        fill = '{
            {16'h0000, 8'h00}, {16'hFFFF, 8'hFF}, {16'h1234, 8'h80}, {16'h1111, 8'h80},
            {16'h2222, 8'h80}, {16'hAAAA, 8'h55}, {16'h5555, 8'hAA}, {16'h0001, 8'hFF},
            {16'h8000, 8'h00}, {16'h0F0F, 8'h01}, {16'hF0F0, 8'hFE}, {16'h3333, 8'h80},
            {16'h4444, 8'h7F}, {16'h6666, 8'h81}, {16'h7777, 8'h40}, {16'h9999, 8'hC0}
        };
        send_request(spq_pkg::OP_DEQ, 16'hFFFF, 8'hFF);
        foreach (fill[i])
            send_request(spq_pkg::OP_ENQ, fill[i][ID_W+PRI_W-1:PRI_W], fill[i][PRI_W-1:0]);
        send_request(spq_pkg::OP_ENQ, 16'hFFFF, 8'hFF);
        repeat (4)
            send_request(spq_pkg::OP_DEQ, 16'h0000, 8'h00);
    endtask

    // Random part: bursts that lean toward filling, draining or neither, with
    // priorities either over the full range or from a narrow set to force ties.
    task automatic run_random(input int count);
        int               sent;
        int               burst;
        int               enq_pct;
        bit               narrow;
        spq_pkg::op_t     op;
        logic [PRI_W-1:0] pri;
        sent = 0;
        while (sent < count)
        begin
            burst  = $urandom_range(40, 1);
            narrow = ($urandom_range(1) == 0);
            case ($urandom_range(3))
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                default: enq_pct = 50;
            endcase
            for (int k = 0; k < burst && sent < count; k++)
            begin
                op = ($urandom_range(99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
                if (narrow)
                begin
                    case ($urandom_range(3))
                        0:       pri = 8'h00;
                        1:       pri = 8'hFF;
                        2:       pri = 8'h80;
                        default: pri = PRI_W'($urandom_range(3));
                    endcase
                end
                else
                begin
                    pri = PRI_W'($urandom_range(255));
                end
                send_request(op, ID_W'($urandom_range(16'hFFFF)), pri);
                sent++;
            end
        end
    endtask

    // Main sequence: reset, three phases with different stall rates, then the verdict.
    initial
    begin
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.operation    <= spq_pkg::OP_ENQ;
        req_ch.entry_id     <= '0;
        req_ch.priority_req <= '0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 35;
                    sink_idle_pct = 61;
                end
                1:
                begin
                    src_idle_pct  = 61;
                    sink_idle_pct = 35;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            if (phase == 0)
                run_directed();
            run_random(ITEMS_PER_PASS);
            drain_results();
        end

        // Idle clocks after the drain catch any stray result beat.
        repeat (4)
            @(posedge clk);

        $display("Ran %0d requests: %0d dequeues served, %0d dequeues on empty,",
                 requests_seen, dequeues_served, empty_refusals);
        $display("%0d enqueues refused on full, %0d mismatches.", full_refusals, mismatches);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
